// ===== rtl/jsu_pkg.sv =====
`default_nettype none
package jsu_pkg;

	localparam int LVL_W   = 32;               // signed Q16.16 level, source, flux
	localparam int COEF_W  = 31;               // unsigned Q15.16 coefficient / depth
	localparam int FRAC_W  = 16;
	localparam int C_W     = 2 * COEF_W;       // c_k = coef * depth, Q30.32
	localparam int PROD_W  = 64;               // one 32x32 signed partial product
	localparam int NUM_W   = 97;               // signed numerator, Q48.48
	localparam int MAG_W   = NUM_W - 1;        // numerator magnitude
	localparam int DEN_W   = 64;               // 1.0 + sum c_k, Q32.32
	localparam int QUOT_W  = 32;
	localparam int SQ_W    = 63;
	localparam int CFG_ADDR_W = 3;

	localparam int NUMER_STAGES = 6;
	localparam int DIV_STAGES   = QUOT_W + 1;  // overflow check plus one stage per bit
	localparam int FIN_STAGES   = 3;
	localparam int NUM_STAGES   = NUMER_STAGES + DIV_STAGES + FIN_STAGES;

	localparam logic [DEN_W-1:0]  DEN_ONE    = DEN_W'(1) << (2 * FRAC_W);
	localparam logic [QUOT_W-1:0] NEG_LIMIT  = QUOT_W'(1) << (QUOT_W - 1);
	localparam logic signed [LVL_W-1:0] LEVEL_MAX = {1'b0, {(LVL_W-1){1'b1}}};
	localparam logic signed [LVL_W-1:0] LEVEL_MIN = {1'b1, {(LVL_W-1){1'b0}}};
	localparam logic [SQ_W-1:0]   SQ_MAX     = {SQ_W{1'b1}};

	typedef enum logic [CFG_ADDR_W-1:0] {
		CFG_ALPHA  = 3'd0,
		CFG_BETA   = 3'd1,
		CFG_KAPPA  = 3'd2,
		CFG_LAMBDA = 3'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [COEF_W-1:0] alpha;
		logic [COEF_W-1:0] beta;
		logic [COEF_W-1:0] kappa;
		logic [COEF_W-1:0] lambda;
	} coef_t;

	typedef struct packed {
		logic [MAG_W-1:0]        mag;
		logic [DEN_W-1:0]        den;
		logic                    neg;
		logic signed [LVL_W-1:0] center;
	} frac_t;

	typedef struct packed {
		logic [QUOT_W-1:0]       quot;
		logic                    ovf;
		logic                    neg;
		logic signed [LVL_W-1:0] center;
	} quot_t;

endpackage
`default_nettype wire

// ===== rtl/jsu_cfg_regs.sv =====
`default_nettype none
module jsu_cfg_regs import jsu_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [COEF_W-1:0]     cfg_data,
	output coef_t                 coef
);

	logic [COEF_W-1:0] alpha_q, beta_q, kappa_q, lambda_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q  <= '0;
			beta_q   <= '0;
			kappa_q  <= '0;
			lambda_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				CFG_ALPHA:  alpha_q  <= cfg_data;
				CFG_BETA:   beta_q   <= cfg_data;
				CFG_KAPPA:  kappa_q  <= cfg_data;
				CFG_LAMBDA: lambda_q <= cfg_data;
				default: ;  // drop writes past the last register
			endcase
		end
	end

	assign coef = '{alpha: alpha_q, beta: beta_q, kappa: kappa_q, lambda: lambda_q};

endmodule
`default_nettype wire

// ===== rtl/jsu_ctrl.sv =====
`default_nettype none
module jsu_ctrl import jsu_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [NUM_STAGES-1:0] en
);

	logic [NUM_STAGES-1:0] vld_q;

	// A stage may load when the output is not stalled, or when it or any stage ahead of it holds a bubble.
	for (genvar k = 0; k < NUM_STAGES; k++) begin : g_en
		assign en[k] = !out_stall || !(&vld_q[NUM_STAGES-1:k]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q[0] <= 1'b0;
		end else if (en[0]) begin
			vld_q[0] <= in_valid;
		end
	end

	for (genvar k = 1; k < NUM_STAGES; k++) begin : g_vld
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (en[k]) begin
				vld_q[k] <= vld_q[k-1];
			end
		end
	end

	assign in_stall  = !en[0];
	assign out_valid = vld_q[NUM_STAGES-1];

endmodule
`default_nettype wire

// ===== rtl/jsu_numer.sv =====
`default_nettype none
module jsu_numer import jsu_pkg::*; (
	input  logic                    clk,
	input  logic [NUMER_STAGES-1:0] en,
	input  coef_t                   coef,
	input  logic signed [LVL_W-1:0] level_east,
	input  logic signed [LVL_W-1:0] level_west,
	input  logic signed [LVL_W-1:0] level_north,
	input  logic signed [LVL_W-1:0] level_south,
	input  logic signed [LVL_W-1:0] level_center,
	input  logic [COEF_W-1:0]       depth_east,
	input  logic [COEF_W-1:0]       depth_west,
	input  logic [COEF_W-1:0]       depth_north,
	input  logic [COEF_W-1:0]       depth_south,
	input  logic signed [LVL_W-1:0] source_term,
	input  logic signed [LVL_W-1:0] flux_diff_x,
	input  logic signed [LVL_W-1:0] flux_diff_y,
	output frac_t                   frac
);

	// stage 1: face coefficients and flux products
	logic [C_W-1:0]           c_s1   [4];
	logic signed [LVL_W-1:0]  lv_s1  [4];
	logic signed [PROD_W-1:0] kfx_s1, lfy_s1;
	logic signed [LVL_W-1:0]  src_s1, ctr_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			c_s1[0]  <= C_W'(coef.alpha) * C_W'(depth_east);
			c_s1[1]  <= C_W'(coef.alpha) * C_W'(depth_west);
			c_s1[2]  <= C_W'(coef.beta)  * C_W'(depth_north);
			c_s1[3]  <= C_W'(coef.beta)  * C_W'(depth_south);
			lv_s1[0] <= level_east;
			lv_s1[1] <= level_west;
			lv_s1[2] <= level_north;
			lv_s1[3] <= level_south;
			kfx_s1   <= PROD_W'($signed({1'b0, coef.kappa}))  * PROD_W'(flux_diff_x);
			lfy_s1   <= PROD_W'($signed({1'b0, coef.lambda})) * PROD_W'(flux_diff_y);
			src_s1   <= source_term;
			ctr_s1   <= level_center;
		end
	end

	// stage 2: split c_k * level into high and low 31-bit halves of c_k
	logic signed [PROD_W-1:0] ph_s2 [4];
	logic signed [PROD_W-1:0] pl_s2 [4];
	logic [DEN_W-1:0]         den_s2;
	logic signed [PROD_W-1:0] kfx_s2, lfy_s2;
	logic signed [LVL_W-1:0]  src_s2, ctr_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int k = 0; k < 4; k++) begin
				ph_s2[k] <= PROD_W'($signed({1'b0, c_s1[k][C_W-1:COEF_W]})) * PROD_W'(lv_s1[k]);
				pl_s2[k] <= PROD_W'($signed({1'b0, c_s1[k][COEF_W-1:0]})) * PROD_W'(lv_s1[k]);
			end
			den_s2 <= DEN_ONE + DEN_W'(c_s1[0]) + DEN_W'(c_s1[1])
				+ DEN_W'(c_s1[2]) + DEN_W'(c_s1[3]);
			kfx_s2 <= kfx_s1;
			lfy_s2 <= lfy_s1;
			src_s2 <= src_s1;
			ctr_s2 <= ctr_s1;
		end
	end

	// stage 3: recombine halves, align source and flux terms to Q48.48
	logic signed [NUM_W-1:0] t_s3 [4];
	logic signed [NUM_W-1:0] e_s3;
	logic [DEN_W-1:0]        den_s3;
	logic signed [LVL_W-1:0] ctr_s3;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int k = 0; k < 4; k++) begin
				t_s3[k] <= (NUM_W'(ph_s2[k]) <<< COEF_W) + NUM_W'(pl_s2[k]);
			end
			e_s3   <= (NUM_W'(src_s2) <<< (2 * FRAC_W)) + (NUM_W'(kfx_s2) <<< FRAC_W)
				+ (NUM_W'(lfy_s2) <<< FRAC_W);
			den_s3 <= den_s2;
			ctr_s3 <= ctr_s2;
		end
	end

	// stage 4: first level of the sum tree
	logic signed [NUM_W-1:0] a_s4, b_s4, e_s4;
	logic [DEN_W-1:0]        den_s4;
	logic signed [LVL_W-1:0] ctr_s4;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			a_s4   <= t_s3[0] + t_s3[1];
			b_s4   <= t_s3[2] + t_s3[3];
			e_s4   <= e_s3;
			den_s4 <= den_s3;
			ctr_s4 <= ctr_s3;
		end
	end

	// stage 5: full signed numerator
	logic signed [NUM_W-1:0] num_s5;
	logic [DEN_W-1:0]        den_s5;
	logic signed [LVL_W-1:0] ctr_s5;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			num_s5 <= a_s4 + b_s4 + e_s4;
			den_s5 <= den_s4;
			ctr_s5 <= ctr_s4;
		end
	end

	// stage 6: sign and magnitude
	logic [MAG_W-1:0]        mag_s6;
	logic                    neg_s6;
	logic [DEN_W-1:0]        den_s6;
	logic signed [LVL_W-1:0] ctr_s6;
	logic [NUM_W-1:0]        num_neg;

	assign num_neg = -num_s5;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			neg_s6 <= num_s5[NUM_W-1];
			mag_s6 <= num_s5[NUM_W-1] ? num_neg[MAG_W-1:0] : num_s5[MAG_W-1:0];
			den_s6 <= den_s5;
			ctr_s6 <= ctr_s5;
		end
	end

	assign frac = '{mag: mag_s6, den: den_s6, neg: neg_s6, center: ctr_s6};

endmodule
`default_nettype wire

// ===== rtl/jsu_div.sv =====
`default_nettype none
module jsu_div import jsu_pkg::*; (
	input  logic                  clk,
	input  logic [DIV_STAGES-1:0] en,
	input  frac_t                 frac,
	output quot_t                 quot
);

	logic [MAG_W-1:0]        rem_s [DIV_STAGES-1];
	logic [DEN_W-1:0]        den_s [DIV_STAGES-1];
	logic [QUOT_W-1:0]       q_s   [1:DIV_STAGES-1];
	logic                    ovf_s [DIV_STAGES];
	logic                    neg_s [DIV_STAGES];
	logic signed [LVL_W-1:0] ctr_s [DIV_STAGES];

	// first stage: the quotient does not fit in QUOT_W bits when mag >= den << QUOT_W
	always_ff @(posedge clk) begin
		if (en[0]) begin
			rem_s[0] <= frac.mag;
			den_s[0] <= frac.den;
			ovf_s[0] <= frac.mag >= {frac.den, {QUOT_W{1'b0}}};
			neg_s[0] <= frac.neg;
			ctr_s[0] <= frac.center;
		end
	end

	// one restoring step per stage, most significant quotient bit first
	for (genvar j = 1; j < DIV_STAGES; j++) begin : g_step
		localparam int Sh = QUOT_W - j;
		logic [MAG_W-1:0] dsh;
		logic [MAG_W:0]   trial;
		logic             ge;

		assign dsh   = MAG_W'(den_s[j-1]) << Sh;
		assign trial = {1'b0, rem_s[j-1]} - {1'b0, dsh};
		assign ge    = !trial[MAG_W];

		always_ff @(posedge clk) begin
			if (en[j]) begin
				ovf_s[j] <= ovf_s[j-1];
				neg_s[j] <= neg_s[j-1];
				ctr_s[j] <= ctr_s[j-1];
			end
		end

		if (j == 1) begin : g_first
			always_ff @(posedge clk) begin
				if (en[j]) begin
					q_s[j] <= {{(QUOT_W-1){1'b0}}, ge};
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (en[j]) begin
					q_s[j] <= {q_s[j-1][QUOT_W-2:0], ge};
				end
			end
		end

		if (j < DIV_STAGES - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en[j]) begin
					rem_s[j] <= ge ? trial[MAG_W-1:0] : rem_s[j-1];
					den_s[j] <= den_s[j-1];
				end
			end
		end
	end

	assign quot = '{
		quot:   q_s[DIV_STAGES-1],
		ovf:    ovf_s[DIV_STAGES-1],
		neg:    neg_s[DIV_STAGES-1],
		center: ctr_s[DIV_STAGES-1]
	};

endmodule
`default_nettype wire

// ===== rtl/jsu_finish.sv =====
`default_nettype none
module jsu_finish import jsu_pkg::*; (
	input  logic                    clk,
	input  logic [FIN_STAGES-1:0]   en,
	input  quot_t                   quot,
	output logic signed [LVL_W-1:0] new_level,
	output logic [SQ_W-1:0]         squared_change
);

	// stage 40: saturate the quotient into a signed level
	logic signed [LVL_W-1:0] newl_s40, ctr_s40;
	logic [QUOT_W-1:0]       q_neg;

	assign q_neg = -quot.quot;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			if (quot.neg) begin
				newl_s40 <= (quot.ovf || quot.quot > NEG_LIMIT) ? LEVEL_MIN : $signed(q_neg);
			end else begin
				newl_s40 <= (quot.ovf || quot.quot[QUOT_W-1]) ? LEVEL_MAX : $signed(quot.quot);
			end
			ctr_s40 <= quot.center;
		end
	end

	// stage 41: magnitude of the change
	logic signed [LVL_W:0]   diff;
	logic [LVL_W:0]          diff_neg;
	logic [LVL_W-1:0]        ad_s41;
	logic signed [LVL_W-1:0] newl_s41;

	assign diff     = (LVL_W+1)'(newl_s40) - (LVL_W+1)'(ctr_s40);
	assign diff_neg = -diff;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			ad_s41   <= diff[LVL_W] ? diff_neg[LVL_W-1:0] : diff[LVL_W-1:0];
			newl_s41 <= newl_s40;
		end
	end

	// stage 42: square and clamp
	logic [2*LVL_W-1:0]      sq;
	logic signed [LVL_W-1:0] lvl_s42;
	logic [SQ_W-1:0]         sq_s42;

	assign sq = (2*LVL_W)'(ad_s41) * (2*LVL_W)'(ad_s41);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			lvl_s42 <= newl_s41;
			sq_s42  <= sq[2*LVL_W-1] ? SQ_MAX : sq[SQ_W-1:0];
		end
	end

	assign new_level      = lvl_s42;
	assign squared_change = sq_s42;

endmodule
`default_nettype wire

// ===== rtl/jacobi_surface_cell_update.sv =====
// Structure: 42 register stages between the input and out_valid (6 numerator,
// overflow check plus 32 one-bit divider stages, 3 saturate/square stages).
// Throughput: one transaction per cycle unless stalled; the 33-stage divider sets the depth.
// Bubbles collapse, so the input keeps taking transactions until every stage is full.
// Reset clears the stage valid bits and the four coefficient registers to zero.
`default_nettype none
module jacobi_surface_cell_update import jsu_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wr_en,
	input  logic [CFG_ADDR_W-1:0]   cfg_addr,
	input  logic [COEF_W-1:0]       cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic signed [LVL_W-1:0] level_east,
	input  logic signed [LVL_W-1:0] level_west,
	input  logic signed [LVL_W-1:0] level_north,
	input  logic signed [LVL_W-1:0] level_south,
	input  logic signed [LVL_W-1:0] level_center,
	input  logic [COEF_W-1:0]       depth_east,
	input  logic [COEF_W-1:0]       depth_west,
	input  logic [COEF_W-1:0]       depth_north,
	input  logic [COEF_W-1:0]       depth_south,
	input  logic signed [LVL_W-1:0] source_term,
	input  logic signed [LVL_W-1:0] flux_diff_x,
	input  logic signed [LVL_W-1:0] flux_diff_y,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [LVL_W-1:0] new_level,
	output logic [SQ_W-1:0]         squared_change
);

	coef_t                 coef;
	frac_t                 frac;
	quot_t                 quot;
	logic [NUM_STAGES-1:0] en;

	jsu_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.coef      (coef)
	);

	jsu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.en        (en)
	);

	jsu_numer u_numer (
		.clk          (clk),
		.en           (en[NUMER_STAGES-1:0]),
		.coef         (coef),
		.level_east   (level_east),
		.level_west   (level_west),
		.level_north  (level_north),
		.level_south  (level_south),
		.level_center (level_center),
		.depth_east   (depth_east),
		.depth_west   (depth_west),
		.depth_north  (depth_north),
		.depth_south  (depth_south),
		.source_term  (source_term),
		.flux_diff_x  (flux_diff_x),
		.flux_diff_y  (flux_diff_y),
		.frac         (frac)
	);

	jsu_div u_div (
		.clk  (clk),
		.en   (en[NUMER_STAGES+DIV_STAGES-1:NUMER_STAGES]),
		.frac (frac),
		.quot (quot)
	);

	jsu_finish u_finish (
		.clk            (clk),
		.en             (en[NUM_STAGES-1:NUM_STAGES-FIN_STAGES]),
		.quot           (quot),
		.new_level      (new_level),
		.squared_change (squared_change)
	);

endmodule
`default_nettype wire

// ===== rtl/jsu_checker.sv =====
`default_nettype none
module jsu_checker import jsu_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_stall,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic signed [LVL_W-1:0] new_level,
	input logic [SQ_W-1:0]         squared_change
);

	// a stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(new_level)
			&& $stable(squared_change))
		else $error("result changed while stalled");

	// input stalls only when the whole pipeline is full behind a stalled output
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with room in the pipeline");

	// an accepted transaction is followed by a valid result at the output stage
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |-> ##NUM_STAGES out_valid)
		else $error("output stage empty one pipeline depth after a transaction");

endmodule

bind jacobi_surface_cell_update jsu_checker u_jsu_checker (.*);
`default_nettype wire
